// File: src/mlpf_pkg.sv
package mlpf_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_BADLEVEL = 2'd3;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam int STATUS_BITS  = 2;
  localparam int LEVEL_BITS   = 4;
  localparam int HANDLE_BITS  = 32;
  localparam int TOTAL_BITS   = 8;

endpackage

// File: src/mlpf_level_table.sv
module mlpf_level_table #(
  parameter int LEVELS = 10,
  parameter int WIDTH  = 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [$clog2(LEVELS)-1:0] raddr,
  output logic [WIDTH-1:0]          rdata,
  input  logic                      we,
  input  logic [$clog2(LEVELS)-1:0] waddr,
  input  logic [WIDTH-1:0]          wdata
);

  logic [WIDTH-1:0] mem [LEVELS];
  logic [LEVELS-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_vld <= valid[raddr];
    end
  end

  // unwritten rows read as all zero
  assign rdata = rd_vld ? rd_q : '0;

endmodule

// File: src/mlpf_entry_store.sv
module mlpf_entry_store #(
  parameter int DEPTH = 160,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/multilevel_priority_fifo_unit.sv
// Multilevel priority FIFO: one FIFO per priority level, level 1 most urgent.
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. kind selects enqueue (level, payload appended to that level)
// or dequeue (oldest entry of the lowest-numbered non-empty level).
// Result channel: done is high for exactly one cycle with status, out_level,
// out_payload and total_count; the receiver cannot hold results off.
// Order: the pointer table read is registered at the accepting edge, then the
// entry store read, then the result register, and done rises with the result.
// The next start is taken in the cycle done is high; no new transaction is
// taken while one is still in flight (busy high).
// The entry store holds LEVELS*LEVEL_DEPTH payloads; the pointer table holds
// head, tail and count per level.
// Reset (rst, synchronous): pointer table valid bits, non-empty flags and the
// total count clear at once; no clearing pass. Entry store contents stay
// undefined and are only read after being written.
module multilevel_priority_fifo_unit #(
  parameter int LEVELS       = 10,
  parameter int LEVEL_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [3:0]  level,
  input  logic [31:0] payload,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  out_level,
  output logic [31:0] out_payload,
  output logic [7:0]  total_count
);

  localparam int QW = $clog2(LEVELS);
  localparam int IW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int TW = 2 * IW + CW;
  localparam int SLOTS = LEVELS * LEVEL_DEPTH;
  localparam int AW = $clog2(SLOTS);
  localparam int SW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam logic [AW-1:0] DEPTH_A = AW'(LEVEL_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(LEVEL_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LEVEL_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_ACCESS} state_t;

  state_t state;

  logic            op_enq;
  logic            op_skip;
  logic [1:0]      op_status;
  logic [QW-1:0]   q_r;
  logic [SW-1:0]   payload_r;
  logic [1:0]      res_status;
  logic [3:0]      res_level;
  logic            res_taken;
  logic [7:0]      total;
  logic [LEVELS-1:0] nonempty;

  logic            in_enq;
  logic            in_bad;
  logic            in_empty;
  logic [QW-1:0]   q_deq;
  logic [QW-1:0]   q_in;

  logic [TW-1:0]   tbl_rdata;
  logic [TW-1:0]   tbl_wdata;
  logic            tbl_we;
  logic [IW-1:0]   t_head;
  logic [IW-1:0]   t_tail;
  logic [CW-1:0]   t_cnt;
  logic            is_full;
  logic            op_remove;

  logic            st_we;
  logic [AW-1:0]   st_waddr;
  logic [AW-1:0]   st_raddr;
  logic [SW-1:0]   st_rdata;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign busy = (state != S_IDLE);

  always_comb begin
    q_deq = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        q_deq = QW'(i);
      end
    end
  end

  assign in_enq   = (kind == mlpf_pkg::KIND_ENQ);
  assign in_bad   = in_enq && ((level == 4'd0) || (int'(level) > LEVELS));
  assign in_empty = !in_enq && (nonempty == '0);
  assign q_in     = in_enq ? QW'(level - 4'd1) : q_deq;

  assign {t_head, t_tail, t_cnt} = tbl_rdata;
  assign is_full   = (t_cnt == FULL_CNT);
  assign op_remove = !op_skip && !op_enq;

  always_comb begin
    tbl_we    = 1'b0;
    st_we     = 1'b0;
    tbl_wdata = tbl_rdata;
    if (state == S_LOOKUP && !op_skip) begin
      if (op_enq) begin
        if (!is_full) begin
          tbl_we    = 1'b1;
          st_we     = 1'b1;
          tbl_wdata = {t_head, next_slot(t_tail), t_cnt + 1'b1};
        end
      end else begin
        tbl_we    = 1'b1;
        tbl_wdata = {next_slot(t_head), t_tail, t_cnt - 1'b1};
      end
    end
  end

  assign st_waddr = AW'(q_r) * DEPTH_A + AW'(t_tail);
  assign st_raddr = AW'(q_r) * DEPTH_A + AW'(t_head);

  mlpf_level_table #(
    .LEVELS (LEVELS),
    .WIDTH  (TW)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .raddr (q_in),
    .rdata (tbl_rdata),
    .we    (tbl_we),
    .waddr (q_r),
    .wdata (tbl_wdata)
  );

  mlpf_entry_store #(
    .DEPTH (SLOTS),
    .WIDTH (SW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (payload_r),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      total       <= '0;
      nonempty    <= '0;
      status      <= mlpf_pkg::ST_OK;
      out_level   <= '0;
      out_payload <= '0;
      total_count <= '0;
    end else begin
      done <= (state == S_ACCESS);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_enq    <= in_enq;
            op_skip   <= in_bad || in_empty;
            op_status <= in_bad ? mlpf_pkg::ST_BADLEVEL : mlpf_pkg::ST_EMPTY;
            q_r       <= q_in;
            payload_r <= SW'(payload);
            state     <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          res_taken <= op_remove;
          res_level <= op_remove ? 4'(32'(q_r) + 1) : 4'd0;
          if (op_skip) begin
            res_status <= op_status;
          end else if (op_enq) begin
            if (is_full) begin
              res_status <= mlpf_pkg::ST_FULL;
            end else begin
              res_status  <= mlpf_pkg::ST_OK;
              nonempty[q_r] <= 1'b1;
              total       <= total + 8'd1;
            end
          end else begin
            res_status    <= mlpf_pkg::ST_OK;
            nonempty[q_r] <= (t_cnt != CW'(1));
            total         <= total - 8'd1;
          end
          state <= S_ACCESS;
        end
        S_ACCESS: begin
          status      <= res_status;
          out_level   <= res_level;
          out_payload <= res_taken ? 32'(st_rdata) : 32'd0;
          total_count <= total;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_after_access: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_ACCESS)
    else $error("result strobe without access cycle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_LOOKUP)
    else $error("accepted transaction did not start lookup");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    done && status == mlpf_pkg::ST_EMPTY |-> total_count == 8'd0)
    else $error("queue empty reported with entries held");

  a_no_removal: assert property (@(posedge clk) disable iff (rst)
    done && status != mlpf_pkg::ST_OK |-> out_level == 4'd0 && out_payload == 32'd0)
    else $error("entry reported on failed transaction");

  a_enq_no_level: assert property (@(posedge clk) disable iff (rst)
    done && status == mlpf_pkg::ST_OK && out_level == 4'd0 |-> out_payload == 32'd0)
    else $error("payload reported on enqueue");

endmodule
